// File: design/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg: shared definitions for the box downscaler
// Field widths, register codes, reset values and the command and status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

	localparam int PIX_W          = 8;
	localparam int NUM_CH         = 3;
	localparam int QUO_W          = 8;
	localparam int STEP_W         = $clog2(QUO_W);
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 13;
	localparam int FACTOR_FIELD_W = 5;
	localparam int MAX_HEIGHT     = 4096;
	localparam int HGT_W          = $clog2(MAX_HEIGHT + 1);

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_FACTOR_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [FACTOR_FIELD_W-1:0] FACTOR_RST = 5'd2;
	localparam logic [CFG_DATA_W-1:0]     WIDTH_RST  = 13'd640;
	localparam logic [CFG_DATA_W-1:0]     HEIGHT_RST = 13'd480;

	typedef struct packed {
		logic capture;
		logic acc;
		logic div_load;
		logic div_step;
		logic load_out;
	} bds_cmd_t;

	typedef struct packed {
		logic emit;
	} bds_stat_t;

endpackage

`default_nettype wire

// File: design/bds_ram.sv
// ----------------------------------------------------------------------------
// bds_ram: simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/bds_ctrl.sv
// ----------------------------------------------------------------------------
// bds_ctrl: sequencing of one pixel through the datapath
// Accept, read-modify-write of the column sum, then for a finished block an
// iterative division and a hand-over to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_ctrl import bds_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire bds_stat_t stat,
	output bds_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	always_comb begin
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.acc      = (state_q == ST_ACC);
		cmd.div_load = (state_q == ST_ACC) && stat.emit;
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (stat.emit) begin
						state_q <= ST_DIV;
						step_q  <= STEP_W'(QUO_W - 1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: design/bds_dp.sv
// ----------------------------------------------------------------------------
// bds_dp: datapath of the box downscaler
// Configuration registers, raster position counters, the column-sum line
// store with its adder, a three-channel restoring divider and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_dp import bds_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [PIX_W-1:0]      red_in,
	input  wire logic [PIX_W-1:0]      green_in,
	input  wire logic [PIX_W-1:0]      blue_in,
	input  wire bds_cmd_t              cmd,
	output bds_stat_t                  stat,
	output logic      [PIX_W-1:0]      red_mean,
	output logic      [PIX_W-1:0]      green_mean,
	output logic      [PIX_W-1:0]      blue_mean,
	output logic                       image_done
);

	localparam int FW    = $clog2(MAX_FACTOR + 1);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int SW    = PIX_W + 2 * $clog2(MAX_FACTOR);
	localparam int DVW   = SW + QUO_W;
	localparam int MW    = (CW > HGT_W) ? CW : HGT_W;
	localparam int XW    = ((MW > FW) ? MW : FW) + 2;
	localparam int ENT_W = NUM_CH * SW;

	// Configuration and its saturated working values
	logic [FACTOR_FIELD_W-1:0] factor_q;
	logic [CFG_DATA_W-1:0]     width_q;
	logic [CFG_DATA_W-1:0]     height_q;
	logic [FW-1:0]             f_eff;
	logic [CW-1:0]             w_eff;
	logic [HGT_W-1:0]          h_eff;
	logic                      restart;

	// Raster position
	logic [CW-1:0]    col_q;
	logic [FW-1:0]    cwb_q;
	logic [CW-1:0]    blkc_q;
	logic [AW-1:0]    bx_q;
	logic [HGT_W-1:0] row_q;
	logic [FW-1:0]    rwb_q;
	logic [HGT_W-1:0] blkr_q;

	logic [XW-1:0] fx, wx, hx;
	logic          in_blk, blk_end, last_blk;
	logic          col_end, row_end, cwb_wrap, rwb_wrap;

	// Captured beat
	logic [PIX_W-1:0] pix_s1 [NUM_CH];
	logic [AW-1:0]    addr_s1;
	logic             first_s1, inblk_s1, emit_s1, last_s1;

	logic [ENT_W-1:0] ram_rdata;
	logic [ENT_W-1:0] ram_wdata;
	logic [SW-1:0]    sum_new [NUM_CH];

	// Divider
	logic [SW-1:0]    rem_q [NUM_CH];
	logic [QUO_W-1:0] quo_q [NUM_CH];
	logic [DVW-1:0]   dvs_q;
	logic [2*FW-1:0]  area;

	logic [PIX_W-1:0] red_q, green_q, blue_q;
	logic             done_q;

	always_comb begin
		if (factor_q == '0) begin
			f_eff = FW'(1);
		end else if (32'(factor_q) > 32'(MAX_FACTOR)) begin
			f_eff = FW'(MAX_FACTOR);
		end else begin
			f_eff = FW'(factor_q);
		end
		if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HGT_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HGT_W'(MAX_HEIGHT);
		end else begin
			h_eff = HGT_W'(height_q);
		end
	end

	assign restart = cfg_we && ((cfg_index == REG_FACTOR) || (cfg_index == REG_WIDTH)
		|| (cfg_index == REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FACTOR: factor_q <= cfg_data[FACTOR_FIELD_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A block lies inside the image when its start plus the factor does not
	// pass the edge; it is the last one when a further block would not fit.
	always_comb begin
		fx       = XW'(f_eff);
		wx       = XW'(w_eff);
		hx       = XW'(h_eff);
		in_blk   = (XW'(blkc_q) + fx <= wx) && (XW'(blkr_q) + fx <= hx);
		blk_end  = (XW'(cwb_q) + 1'b1 == fx) && (XW'(rwb_q) + 1'b1 == fx);
		last_blk = (XW'(blkc_q) + (fx << 1) > wx) && (XW'(blkr_q) + (fx << 1) > hx);
		col_end  = (XW'(col_q) + 1'b1 >= wx);
		row_end  = (XW'(row_q) + 1'b1 >= hx);
		cwb_wrap = (XW'(cwb_q) + 1'b1 >= fx);
		rwb_wrap = (XW'(rwb_q) + 1'b1 >= fx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			cwb_q  <= '0;
			blkc_q <= '0;
			bx_q   <= '0;
			row_q  <= '0;
			rwb_q  <= '0;
			blkr_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			cwb_q  <= '0;
			blkc_q <= '0;
			bx_q   <= '0;
			row_q  <= '0;
			rwb_q  <= '0;
			blkr_q <= '0;
		end else if (cmd.capture) begin
			if (col_end) begin
				col_q  <= '0;
				cwb_q  <= '0;
				blkc_q <= '0;
				bx_q   <= '0;
				if (row_end) begin
					row_q  <= '0;
					rwb_q  <= '0;
					blkr_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					if (rwb_wrap) begin
						rwb_q  <= '0;
						blkr_q <= blkr_q + HGT_W'(f_eff);
					end else begin
						rwb_q <= rwb_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (cwb_wrap) begin
					cwb_q  <= '0;
					blkc_q <= blkc_q + CW'(f_eff);
					bx_q   <= bx_q + 1'b1;
				end else begin
					cwb_q <= cwb_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_s1 <= 1'b0;
			inblk_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
		end else if (cmd.capture) begin
			first_s1 <= (rwb_q == '0) && (cwb_q == '0);
			inblk_s1 <= in_blk;
			emit_s1  <= in_blk && blk_end;
			last_s1  <= last_blk;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_s1[0] <= red_in;
			pix_s1[1] <= green_in;
			pix_s1[2] <= blue_in;
			addr_s1   <= bx_q;
		end
	end

	assign stat.emit = emit_s1;

	// A block's sum starts afresh at its top-left pixel: the stale store word
	// left there by the previous block row is ignored rather than cleared.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum_new[c] = (first_s1 ? '0 : ram_rdata[c*SW +: SW]) + SW'(pix_s1[c]);
			ram_wdata[c*SW +: SW] = sum_new[c];
		end
	end

	bds_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_WIDTH)
	) u_sums (
		.clk  (clk),
		.we   (cmd.acc && inblk_s1),
		.waddr(addr_s1),
		.wdata(ram_wdata),
		.re   (cmd.capture),
		.raddr(bx_q),
		.rdata(ram_rdata)
	);

	assign area = (2*FW)'(f_eff) * (2*FW)'(f_eff);

	// Restoring division, one quotient bit per cycle, most significant first.
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvs_q <= DVW'(area) << (QUO_W - 1);
			for (int c = 0; c < NUM_CH; c++) begin
				rem_q[c] <= sum_new[c];
				quo_q[c] <= '0;
			end
		end else if (cmd.div_step) begin
			dvs_q <= dvs_q >> 1;
			for (int c = 0; c < NUM_CH; c++) begin
				if (DVW'(rem_q[c]) >= dvs_q) begin
					rem_q[c] <= rem_q[c] - SW'(dvs_q);
					quo_q[c] <= {quo_q[c][QUO_W-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			red_q   <= quo_q[0];
			green_q <= quo_q[1];
			blue_q  <= quo_q[2];
			done_q  <= last_s1;
		end
	end

	assign red_mean   = red_q;
	assign green_mean = green_q;
	assign blue_mean  = blue_q;
	assign image_done = done_q;

endmodule

`default_nettype wire

// File: design/box_downscale_rgb_top.sv
// ----------------------------------------------------------------------------
// box_downscale_rgb_top: integer box-filter downscaler for RGB pixels
// Averages each factor-by-factor block of a raster pixel stream into one
// output pixel, per channel, with the quotient truncated.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   red_in, green_in, blue_in
//  output   out_valid / out_ready red_mean, green_mean, blue_mean, image_done
//  config   cfg_we (no wait)      cfg_index, cfg_data
//
// A pixel that does not complete a block passes through accept, then the
// read-modify-write of its column sum through the single read port of the
// line store. A pixel that completes a block takes the same steps, then the
// bit-per-cycle divider and the load of the output register, plus any wait
// of that register for out_ready.
// The next beat is accepted while a result waits in the output register.
// Reset needs no clearing pass over the line store.
// ----------------------------------------------------------------------------
`default_nettype none

module box_downscale_rgb_top import bds_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_W-1:0]      red_in,
	input  wire logic [PIX_W-1:0]      green_in,
	input  wire logic [PIX_W-1:0]      blue_in,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [PIX_W-1:0]      red_mean,
	output logic      [PIX_W-1:0]      green_mean,
	output logic      [PIX_W-1:0]      blue_mean,
	output logic                       image_done
);

	bds_cmd_t  cmd;
	bds_stat_t stat;

	bds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bds_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.cmd       (cmd),
		.stat      (stat),
		.red_mean  (red_mean),
		.green_mean(green_mean),
		.blue_mean (blue_mean),
		.image_done(image_done)
	);

endmodule

`default_nettype wire

// File: design/bds_checker.sv
// ----------------------------------------------------------------------------
// bds_props: port-level checks for the box downscaler
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_props import bds_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PIX_W-1:0] red_mean,
	input wire logic [PIX_W-1:0] green_mean,
	input wire logic [PIX_W-1:0] blue_mean,
	input wire logic             image_done
);

	// A stalled result beat stays offered with the same payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({red_mean, green_mean, blue_mean, image_done}))
		else $error("output beat withdrawn or changed while stalled");

	// One pixel at a time: the cycle after an accepted beat is busy.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on two consecutive cycles");

	// A fresh result is only loaded while no input beat can be taken.
	a_result_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the input side was idle");

	// Nothing is offered straight after reset.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n ##1 arst_n |-> !out_valid)
		else $error("output valid following reset");

endmodule

bind box_downscale_rgb_top bds_props u_bds_props (.*);

`default_nettype wire

// File: verif/bds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_checker: block-mean predictor and scoreboard for the box downscaler
// Watches the configuration port and both pixel channels. Keeps its own copy
// of the registers, the per-column sums and the raster position, works out the
// mean pixel that each accepted input beat completes, and compares every
// output beat with the oldest predicted mean.
// ----------------------------------------------------------------------------
module bds_checker import bds_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic [PIX_W-1:0]      red_in,
	input  wire logic [PIX_W-1:0]      green_in,
	input  wire logic [PIX_W-1:0]      blue_in,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic [PIX_W-1:0]      red_mean,
	input  wire logic [PIX_W-1:0]      green_mean,
	input  wire logic [PIX_W-1:0]      blue_mean,
	input  wire logic                  image_done,
	output int                         pending,
	output int                         errors
);

	localparam int SUM_W       = PIX_W + 2 * $clog2(MAX_FACTOR);
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} rgb_sum_t;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
		logic             done;
	} block_mean_t;

	logic [FACTOR_FIELD_W-1:0] factor_reg;
	logic [CFG_DATA_W-1:0]     width_reg;
	logic [CFG_DATA_W-1:0]     height_reg;
	rgb_sum_t                  column_sum [MAX_WIDTH];
	int unsigned               col_pos;
	int unsigned               row_pos;
	int unsigned               col_in_block;
	int unsigned               row_in_block;
	block_mean_t               mean_q [$];
	int                        fail_cnt = 0;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic restart_image();
		for (int i = 0; i < MAX_WIDTH; i++)
			column_sum[i] = '0;
		col_pos      = 0;
		row_pos      = 0;
		col_in_block = 0;
		row_in_block = 0;
	endtask

	task automatic accumulate_pixel(input logic [PIX_W-1:0] r, g, b);
		int unsigned f, w, h, out_w, out_h, bx, by, area;
		block_mean_t m;
		f     = clamp_dim(32'(factor_reg), MAX_FACTOR);
		w     = clamp_dim(32'(width_reg), MAX_WIDTH);
		h     = clamp_dim(32'(height_reg), MAX_HEIGHT);
		out_w = w / f;
		out_h = h / f;
		if (col_pos >= w || row_pos >= h)
			restart_image();
		bx = col_pos / f;
		by = row_pos / f;
		// Pixels of partial blocks at the right and bottom edges add to nothing.
		if (bx < out_w && by < out_h) begin
			column_sum[bx].r = column_sum[bx].r + SUM_W'(r);
			column_sum[bx].g = column_sum[bx].g + SUM_W'(g);
			column_sum[bx].b = column_sum[bx].b + SUM_W'(b);
			if (col_in_block == f - 1 && row_in_block == f - 1) begin
				area   = f * f;
				m.r    = PIX_W'(column_sum[bx].r / area);
				m.g    = PIX_W'(column_sum[bx].g / area);
				m.b    = PIX_W'(column_sum[bx].b / area);
				m.done = (bx == out_w - 1 && by == out_h - 1);
				mean_q.push_back(m);
				column_sum[bx] = '0;
			end
		end
		if (col_pos + 1 >= w) begin
			col_pos      = 0;
			col_in_block = 0;
			if (row_pos + 1 >= h) begin
				row_pos      = 0;
				row_in_block = 0;
			end else begin
				row_pos++;
				row_in_block = (row_in_block + 1 >= f) ? 0 : row_in_block + 1;
			end
		end else begin
			col_pos++;
			col_in_block = (col_in_block + 1 >= f) ? 0 : col_in_block + 1;
		end
	endtask

	task automatic check_mean();
		block_mean_t exp_m;
		block_mean_t got;
		got = {red_mean, green_mean, blue_mean, image_done};
		if (mean_q.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= MAX_REPORTS)
				$display("%0t: output beat r=%0d g=%0d b=%0d done=%0d, no block pending",
					$time, got.r, got.g, got.b, got.done);
			return;
		end
		exp_m = mean_q.pop_front();
		if (got !== exp_m) begin
			fail_cnt++;
			if (fail_cnt <= MAX_REPORTS) begin
				$write("%0t: block mean mismatch: expected r=%0d g=%0d b=%0d done=%0d,",
					$time, exp_m.r, exp_m.g, exp_m.b, exp_m.done);
				$display(" got r=%0d g=%0d b=%0d done=%0d",
					got.r, got.g, got.b, got.done);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_reg = FACTOR_RST;
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			restart_image();
			mean_q.delete();
		end else begin
			if (out_valid && out_ready)
				check_mean();
			// Any write to a real register also starts a fresh image.
			if (cfg_we) begin
				case (cfg_index)
					REG_FACTOR: begin
						factor_reg = cfg_data[FACTOR_FIELD_W-1:0];
						restart_image();
					end
					REG_WIDTH: begin
						width_reg = cfg_data;
						restart_image();
					end
					REG_HEIGHT: begin
						height_reg = cfg_data;
						restart_image();
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				accumulate_pixel(red_in, green_in, blue_in);
		end
		pending <= mean_q.size();
		errors  <= fail_cnt;
	end

endmodule

// File: verif/tb_box_downscale_rgb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_downscale_rgb_top: stimulus and verdict for the box downscaler
// Drives a short set of directed images (register extremes, saturated and
// zero sizes, partial blocks, factors too large for the image, image wrap and
// writes to the spare index), then random images with random pixel content.
// Both channels idle at random; the checker beside the block does the rest.
// ----------------------------------------------------------------------------
module tb_box_downscale_rgb_top;

	import bds_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES    = 16;
	localparam int TAIL_CYCLES      = 32;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS     = 832;
	localparam int MAX_PHASE_PIXELS = 300;

	typedef enum int {LV_RANDOM, LV_EXTREME, LV_FULL, LV_HIGH, LV_ZERO} level_mode_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic [PIX_W-1:0]      red_in     = '0;
	logic [PIX_W-1:0]      green_in   = '0;
	logic [PIX_W-1:0]      blue_in    = '0;
	logic                  out_ready  = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic [PIX_W-1:0]      red_mean;
	logic [PIX_W-1:0]      green_mean;
	logic [PIX_W-1:0]      blue_mean;
	logic                  image_done;
	int                    pending_results;
	int                    fail_count;

	logic                      hold_req   = 1'b0;
	logic [FACTOR_FIELD_W-1:0] cur_factor = FACTOR_RST;
	logic [CFG_DATA_W-1:0]     cur_width  = WIDTH_RST;
	logic [CFG_DATA_W-1:0]     cur_height = HEIGHT_RST;
	int                        calm_left  = 0;

	box_downscale_rgb_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_mean   (red_mean),
		.green_mean (green_mean),
		.blue_mean  (blue_mean),
		.image_done (image_done)
	);

	bds_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_mean   (red_mean),
		.green_mean (green_mean),
		.blue_mean  (blue_mean),
		.image_done (image_done),
		.pending    (pending_results),
		.errors     (fail_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [PIX_W-1:0] pick_level(level_mode_t mode);
		case (mode)
			LV_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
			LV_FULL:    return '1;
			LV_HIGH:    return PIX_W'($urandom_range(240, 255));
			LV_ZERO:    return '0;
			default:    return PIX_W'($urandom);
		endcase
	endfunction

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic wait_for_results(int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Registers change only once the block has gone quiet; a pixel that makes
	// no output may still be in flight, hence the settle time.
	task automatic reconfigure(logic [2:0] mask, logic [CFG_DATA_W-1:0] fd,
			logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] hd, logic spare);
		wait_for_results(SETTLE_CYCLES);
		if (mask[0]) begin
			write_reg(REG_FACTOR, fd);
			cur_factor = fd[FACTOR_FIELD_W-1:0];
		end
		if (mask[1]) begin
			write_reg(REG_WIDTH, wd);
			cur_width = wd;
		end
		if (mask[2]) begin
			write_reg(REG_HEIGHT, hd);
			cur_height = hd;
		end
		if (spare)
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic run_pixels(int count, level_mode_t mode);
		int gap;
		int roll;
		for (int i = 0; i < count; i++) begin
			in_valid <= 1'b1;
			red_in   <= pick_level(mode);
			green_in <= pick_level(mode);
			blue_in  <= pick_level(mode);
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			// The beat went in at this edge; decide on any pause before the next.
			gap  = 0;
			roll = $urandom_range(0, 999);
			if (calm_left > 0)
				calm_left--;
			else if (roll < 10)
				calm_left = $urandom_range(30, 150);
			else if (roll < 13)
				wait_for_results(0);
			else if (roll < 400)
				gap = $urandom_range(1, 3);
			else if (roll < 470)
				gap = $urandom_range(4, 12);
			else if (roll < 485)
				gap = $urandom_range(20, 60);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Output side: random stalls, calm stretches, and one long hold-off on request.
	initial begin
		int  steady_left;
		int  run;
		bit  hold_taken;
		steady_left = 0;
		hold_taken  = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (steady_left == 0 && $urandom_range(0, 99) < 35) begin
				out_ready <= 1'b0;
				if ($urandom_range(0, 19) == 0)
					repeat ($urandom_range(20, 60)) @(posedge clk);
				else
					repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_ready <= 1'b1;
			run = $urandom_range(1, 6);
			repeat (run) @(posedge clk);
			if (steady_left > 0)
				steady_left = (steady_left > run) ? steady_left - run : 0;
			else if ($urandom_range(0, 29) == 0)
				steady_left = $urandom_range(50, 300);
		end
	end

	initial begin
		logic [2:0]                mask;
		logic [FACTOR_FIELD_W-1:0] f_raw;
		int unsigned               f_eff, w_eff, h_eff, k, w_raw, h_raw, count;
		int                        random_items;
		int                        roll;
		bit                        first_phase;
		level_mode_t               mode;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Width only: factor and height keep their reset values.
		reconfigure(3'b010, '0, 13'd4, '0, 1'b0);
		run_pixels(8, LV_EXTREME);

		// One pixel per output over the reset height; the output side holds off
		// for a long stretch, and the input pauses once until all means are out.
		reconfigure(3'b011, {8'($urandom), 5'd1}, 13'd1, '0, 1'b0);
		hold_req = 1'b1;
		run_pixels(200, LV_RANDOM);
		wait_for_results(0);
		run_pixels(281, LV_RANDOM);

		// Zero factor and zero sizes act as one.
		reconfigure(3'b111, {8'($urandom), 5'd0}, 13'd0, 13'd0, 1'b0);
		run_pixels(3, LV_HIGH);

		// Factor above the maximum saturates; a full block of white stays white.
		reconfigure(3'b111, {8'($urandom), 5'd31}, 13'd16, 13'd16, 1'b0);
		run_pixels(256, LV_FULL);

		// Factor too large for the image width: nothing comes out.
		reconfigure(3'b111, {8'($urandom), 5'd4}, 13'd3, 13'd8, 1'b0);
		run_pixels(24, LV_RANDOM);

		// Partial blocks at the edges, two images back to back.
		reconfigure(3'b111, {8'($urandom), 5'd2}, 13'd5, 13'd5, 1'b0);
		run_pixels(50, LV_EXTREME);

		// A write to the spare index must leave the image where it was.
		reconfigure(3'b111, {8'($urandom), 5'd2}, 13'd4, 13'd4, 1'b0);
		run_pixels(6, LV_RANDOM);
		reconfigure(3'b000, '0, '0, '0, 1'b1);
		run_pixels(10, LV_RANDOM);

		// Oversized width saturates to the line store size, oversized height to the maximum height.
		reconfigure(3'b111, {8'($urandom), 5'd1}, 13'd8191, 13'd1, 1'b0);
		run_pixels(40, LV_RANDOM);
		reconfigure(3'b111, {8'($urandom), 5'd1}, 13'd1, 13'd8191, 1'b0);
		run_pixels(40, LV_RANDOM);

		random_items = 0;
		first_phase  = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				f_raw = FACTOR_FIELD_W'($urandom_range(1, 4));
			else if (roll < 85)
				f_raw = FACTOR_FIELD_W'($urandom_range(5, 16));
			else if (roll < 92)
				f_raw = '0;
			else
				f_raw = FACTOR_FIELD_W'($urandom_range(17, 31));
			f_eff = clamp_dim(32'(f_raw), MAX_FACTOR_DEF);

			k     = (f_eff > 8) ? $urandom_range(1, 2) : $urandom_range(1, 5);
			w_raw = f_eff * k + ($urandom_range(0, 1) ? $urandom_range(0, f_eff - 1) : 0);
			roll  = $urandom_range(0, 99);
			if (roll < 5)
				w_raw = $urandom_range(1, f_eff);
			else if (roll < 8)
				w_raw = 0;

			k     = (f_eff > 8) ? 1 : $urandom_range(1, 4);
			h_raw = f_eff * k + ($urandom_range(0, 1) ? $urandom_range(0, f_eff - 1) : 0);
			roll  = $urandom_range(0, 99);
			if (roll < 5)
				h_raw = $urandom_range(1, f_eff);
			else if (roll < 8)
				h_raw = 0;

			mask = (first_phase || $urandom_range(0, 9) < 7) ? 3'b111 : 3'($urandom_range(1, 6));
			reconfigure(mask, {8'($urandom), f_raw}, CFG_DATA_W'(w_raw), CFG_DATA_W'(h_raw),
				$urandom_range(0, 4) == 0);

			w_eff = clamp_dim(32'(cur_width), MAX_WIDTH_DEF);
			h_eff = clamp_dim(32'(cur_height), MAX_HEIGHT);
			count = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff);
			if (count > MAX_PHASE_PIXELS)
				count = MAX_PHASE_PIXELS;
			if (count > unsigned'(RANDOM_ITEMS - random_items))
				count = unsigned'(RANDOM_ITEMS - random_items);
			mode = ($urandom_range(0, 1) == 0) ? LV_RANDOM : level_mode_t'($urandom_range(1, 4));
			run_pixels(int'(count), mode);
			random_items += int'(count);
			first_phase   = 1'b0;
		end

		wait_for_results(TAIL_CYCLES);
		if (fail_count == 0 && pending_results == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
